// ===== rtl/core/line_follow_steering_assert.svh =====
// Assertion macros shared by the line follow steering checkers.
// Clock and reset are passed in so the macros stay module independent.
`ifndef LINE_FOLLOW_STEERING_ASSERT_SVH
`define LINE_FOLLOW_STEERING_ASSERT_SVH

// Concurrent check, masked while reset is asserted.
`define LFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define LFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lfs_pkg.sv =====
// Package for the line follow steering block: widths, codes, structs and
// the sensor weight function. No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int LFS_READING_WIDTH = 16;
  localparam int NUM_SENSORS       = 8;
  localparam int SAT_W             = 16;
  localparam int BAND_W            = 14;
  localparam int SPEED_W           = 7;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  // Reset values of the configuration registers
  localparam logic [SAT_W-1:0]  SAT_LEVEL_RST  = 16'd1000;
  localparam logic [BAND_W-1:0] DEAD_BAND_RST  = 14'd20;
  localparam logic [BAND_W-1:0] NEAR_LIMIT_RST = 14'd25;
  localparam logic [BAND_W-1:0] FAR_LIMIT_RST  = 14'd30;

  // Value substituted for a saturated reading
  localparam int SAT_VALUE = 5;

  localparam logic [SPEED_W-1:0] SPD_CRUISE_LEFT  = 7'd25;
  localparam logic [SPEED_W-1:0] SPD_CRUISE_RIGHT = 7'd30;
  localparam logic [SPEED_W-1:0] SPD_PIVOT_FAST   = 7'd45;
  localparam logic [SPEED_W-1:0] SPD_PIVOT_MID    = 7'd35;
  localparam logic [SPEED_W-1:0] SPD_PIVOT_SLOW   = 7'd25;
  localparam logic [SPEED_W-1:0] SPD_STOP         = 7'd0;

  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_LEFT     = 2'd1,
    TURN_RIGHT    = 2'd2
  } turn_mode_t;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_GREEN = 2'd1,
    LED_BLUE  = 2'd2,
    LED_RED   = 2'd3
  } led_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SATURATION = 2'd0,
    CFG_DEAD_BAND  = 2'd1,
    CFG_NEAR_LIMIT = 2'd2,
    CFG_FAR_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SAT_W-1:0]  saturation_level;
    logic [BAND_W-1:0] dead_band;
    logic [BAND_W-1:0] near_limit;
    logic [BAND_W-1:0] far_limit;
  } cfg_t;

  typedef struct packed {
    logic               drive_update;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    led_t               led;
    turn_mode_t         mode;
  } steer_t;

  // Weight of sensor i in half sensor pitches, leftmost negative
  function automatic int sensor_weight(input int idx);
    return 2 * idx - 7;
  endfunction

endpackage

// ===== rtl/core/lfs_chan_if.sv =====
// Handshake channel interfaces for sensor samples and steering results.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

interface lfs_sample_if
  import lfs_pkg::*;
#(
  parameter int READING_WIDTH = LFS_READING_WIDTH
) ();
  logic                     valid;
  logic                     ready;
  logic [READING_WIDTH-1:0] reading_0;
  logic [READING_WIDTH-1:0] reading_1;
  logic [READING_WIDTH-1:0] reading_2;
  logic [READING_WIDTH-1:0] reading_3;
  logic [READING_WIDTH-1:0] reading_4;
  logic [READING_WIDTH-1:0] reading_5;
  logic [READING_WIDTH-1:0] reading_6;
  logic [READING_WIDTH-1:0] reading_7;

  modport source (
    output valid, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7,
    input  ready
  );
  modport sink (
    input  valid, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7,
    output ready
  );
endinterface

interface lfs_result_if
  import lfs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               drive_update;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic [1:0]         led_colour;
  logic [1:0]         turn_mode_out;

  modport source (
    output valid, drive_update, left_speed, right_speed, led_colour, turn_mode_out,
    input  ready
  );
  modport sink (
    input  valid, drive_update, left_speed, right_speed, led_colour, turn_mode_out,
    output ready
  );
endinterface

// ===== rtl/core/lfs_cfg_regs.sv =====
// Configuration register bank: saturation level and the three band limits.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_cfg_regs
  import lfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SATURATION: cfg_nxt.saturation_level = cfg_wdata[SAT_W-1:0];
        CFG_DEAD_BAND:  cfg_nxt.dead_band        = cfg_wdata[BAND_W-1:0];
        CFG_NEAR_LIMIT: cfg_nxt.near_limit       = cfg_wdata[BAND_W-1:0];
        CFG_FAR_LIMIT:  cfg_nxt.far_limit        = cfg_wdata[BAND_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.saturation_level <= SAT_LEVEL_RST;
      cfg_r.dead_band        <= DEAD_BAND_RST;
      cfg_r.near_limit       <= NEAR_LIMIT_RST;
      cfg_r.far_limit        <= FAR_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/lfs_pos_sum.sv =====
// Weighted line position sum over the eight clipped sensor readings.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_pos_sum
  import lfs_pkg::*;
#(
  parameter int READING_WIDTH = LFS_READING_WIDTH,
  parameter int SUM_W         = LFS_READING_WIDTH + 5
) (
  input  logic [READING_WIDTH-1:0] rd [NUM_SENSORS],
  input  logic [SAT_W-1:0]         saturation_level,
  output logic signed [SUM_W-1:0]  pos_sum
);

  logic signed [SUM_W-1:0] term [NUM_SENSORS];

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_term
    logic [SUM_W-1:0]        mag;
    logic signed [SUM_W-1:0] wgt;

    assign mag = (SAT_W'(rd[g]) >= saturation_level) ? SUM_W'(SAT_VALUE) : SUM_W'(rd[g]);
    assign wgt = SUM_W'(sensor_weight(g));
    // constant weight, reduces to a shift-add
    assign term[g] = SUM_W'($signed(mag) * wgt);
  end

  assign pos_sum = ((term[0] + term[1]) + (term[2] + term[3]))
                 + ((term[4] + term[5]) + (term[6] + term[7]));

endmodule

// ===== rtl/core/lfs_steer_ctrl.sv =====
// Turn memory and steering decision from the position sum and band limits.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_steer_ctrl
  import lfs_pkg::*;
#(
  parameter int SUM_W = LFS_READING_WIDTH + 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic signed [SUM_W-1:0] pos_sum,
  input  cfg_t                    cfg,
  output steer_t                  res
);

  turn_mode_t turn_mode_r;
  turn_mode_t turn_mode_nxt;

  // sum is in half pitches, so limits are doubled
  logic signed [SUM_W-1:0] db2;
  logic signed [SUM_W-1:0] nl2;
  logic signed [SUM_W-1:0] fl2;

  assign db2 = $signed(SUM_W'({cfg.dead_band, 1'b0}));
  assign nl2 = $signed(SUM_W'({cfg.near_limit, 1'b0}));
  assign fl2 = $signed(SUM_W'({cfg.far_limit, 1'b0}));

  always_comb begin
    res.drive_update = 1'b0;
    res.left_speed   = SPD_STOP;
    res.right_speed  = SPD_STOP;
    res.led          = LED_KEEP;
    turn_mode_nxt    = turn_mode_r;

    priority if (pos_sum == '0) begin
      turn_mode_nxt    = TURN_STRAIGHT;
      res.drive_update = 1'b1;
      res.left_speed   = SPD_CRUISE_LEFT;
      res.right_speed  = SPD_CRUISE_RIGHT;
      res.led          = LED_GREEN;
    end else if ((pos_sum < 0 && pos_sum > -db2) || (pos_sum > 0 && pos_sum < db2)) begin
      // inside the dead band: cruise, or just drop an active turn
      if (turn_mode_r == TURN_STRAIGHT) begin
        res.drive_update = 1'b1;
        res.left_speed   = SPD_CRUISE_LEFT;
        res.right_speed  = SPD_CRUISE_RIGHT;
        res.led          = LED_GREEN;
      end else begin
        turn_mode_nxt = TURN_STRAIGHT;
      end
    end else if (pos_sum < 0) begin
      if (turn_mode_r == TURN_LEFT) begin
        res.drive_update = 1'b1;
        res.led          = LED_BLUE;
        priority if (pos_sum < -fl2) res.left_speed = SPD_PIVOT_FAST;
        else if (pos_sum > -nl2)     res.left_speed = SPD_PIVOT_MID;
        else                         res.left_speed = SPD_PIVOT_SLOW;
      end else begin
        turn_mode_nxt = TURN_LEFT;
      end
    end else begin
      res.led = LED_RED;
      if (turn_mode_r == TURN_RIGHT) begin
        res.drive_update = 1'b1;
        priority if (pos_sum > fl2) res.right_speed = SPD_PIVOT_FAST;
        else if (pos_sum < nl2)     res.right_speed = SPD_PIVOT_MID;
        else                        res.right_speed = SPD_PIVOT_SLOW;
      end else begin
        turn_mode_nxt = TURN_RIGHT;
      end
    end

    res.mode = turn_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_mode_r <= TURN_STRAIGHT;
    end else if (advance) begin
      turn_mode_r <= turn_mode_nxt;
    end
  end

endmodule

// ===== rtl/core/line_follow_steering.sv =====
// Line follow steering block: sample register, position sum, turn memory
// and result register. Depends on lfs_pkg, lfs_chan_if and the lfs_* modules.
//
// Usage:
//   in_chan  : one transaction carries eight sensor readings (one sample).
//   out_chan : one transaction per sample: drive_update, left/right speed in
//              hundredths, led_colour and the turn mode after the sample.
//   cfg_*    : write port for saturation level, dead band, near and far limit;
//              write only while no sample is in flight.
// Path: an accepted sample waits in the sample register; its result is loaded
//   into the result register once that register is free or being emptied.
// Throughput: one sample per cycle while out_chan is not held; the weighted
//   sum and the turn decision sit in one stage between the two registers.
// Reset (rst_n low, synchronous): both stages empty, turn memory straight,
//   configuration back to 1000 / 20 / 25 / 30.
// Stall: while out_chan is held, the result register keeps its transaction
//   and the sample register can still take one more sample; after that
//   in_chan.ready drops until the result is taken.
`timescale 1ns / 1ps

module line_follow_steering
  import lfs_pkg::*;
#(
  parameter int READING_WIDTH = LFS_READING_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lfs_sample_if.sink            in_chan,
  lfs_result_if.source          out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = READING_WIDTH + 5;

  cfg_t cfg;

  logic [READING_WIDTH-1:0] rd_r [NUM_SENSORS];
  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  steer_t                   out_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;

  logic                     in_fire;
  logic                     advance;
  logic signed [SUM_W-1:0]  pos_sum;
  steer_t                   res;

  lfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r[0] <= in_chan.reading_0;
      rd_r[1] <= in_chan.reading_1;
      rd_r[2] <= in_chan.reading_2;
      rd_r[3] <= in_chan.reading_3;
      rd_r[4] <= in_chan.reading_4;
      rd_r[5] <= in_chan.reading_5;
      rd_r[6] <= in_chan.reading_6;
      rd_r[7] <= in_chan.reading_7;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  lfs_pos_sum #(
    .READING_WIDTH (READING_WIDTH),
    .SUM_W         (SUM_W)
  ) u_sum (
    .rd               (rd_r),
    .saturation_level (cfg.saturation_level),
    .pos_sum          (pos_sum)
  );

  lfs_steer_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .pos_sum (pos_sum),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.drive_update  = out_r.drive_update;
  assign out_chan.left_speed    = out_r.left_speed;
  assign out_chan.right_speed   = out_r.right_speed;
  assign out_chan.led_colour    = out_r.led;
  assign out_chan.turn_mode_out = out_r.mode;

endmodule

// ===== rtl/core/lfs_checker.sv =====
// Port level checker for line_follow_steering, attached by bind.
// Depends on lfs_pkg and line_follow_steering_assert.svh.
`timescale 1ns / 1ps
`include "line_follow_steering_assert.svh"

module lfs_checker
  import lfs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               drive_update,
  input logic [SPEED_W-1:0] left_speed,
  input logic [SPEED_W-1:0] right_speed,
  input logic [1:0]         led_colour,
  input logic [1:0]         turn_mode_out
);

  logic left_pivot;
  logic straight_drive;

  assign left_pivot     = out_valid && drive_update && left_speed != SPD_STOP
                          && right_speed == SPD_STOP;
  assign straight_drive = out_valid && drive_update && left_speed == SPD_CRUISE_LEFT
                          && right_speed == SPD_CRUISE_RIGHT;

  `LFS_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "result valid after reset")
  `LFS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `LFS_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")
  `LFS_ASSERT(a_idle_speeds, clk, rst_n, out_valid && !drive_update |-> left_speed == SPD_STOP && right_speed == SPD_STOP, "speeds set without update")
  `LFS_ASSERT(a_mode_match, clk, rst_n, (left_pivot |-> turn_mode_out == TURN_LEFT && led_colour == LED_BLUE) and (straight_drive |-> turn_mode_out == TURN_STRAIGHT && led_colour == LED_GREEN), "drive inconsistent with turn mode")

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .drive_update  (out_chan.drive_update),
  .left_speed    (out_chan.left_speed),
  .right_speed   (out_chan.right_speed),
  .led_colour    (out_chan.led_colour),
  .turn_mode_out (out_chan.turn_mode_out)
);

// ===== dv/line_follow_steering_tb.sv =====
// Self-checking testbench for line_follow_steering: drives sensor samples and
// register writes, predicts every steering result and checks it field by field.
// Depends on lfs_pkg, lfs_chan_if and the line_follow_steering RTL.
`timescale 1ns / 1ps

module line_follow_steering_tb;
  import lfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  typedef logic [NUM_SENSORS-1:0][LFS_READING_WIDTH-1:0] sample_t;

  // Tracks configuration and turn memory, holds expected results in order.
  class steering_scoreboard;
    logic [SAT_W-1:0]  sat_level;
    logic [BAND_W-1:0] dead_band;
    logic [BAND_W-1:0] near_limit;
    logic [BAND_W-1:0] far_limit;
    turn_mode_t        turn_mode;
    steer_t            steer_q[$];
    int errors;
    int samples;
    int checked;
    int pivots;
    int arms;
    int clears;

    function new();
      sat_level  = SAT_LEVEL_RST;
      dead_band  = DEAD_BAND_RST;
      near_limit = NEAR_LIMIT_RST;
      far_limit  = FAR_LIMIT_RST;
      turn_mode  = TURN_STRAIGHT;
      errors = 0; samples = 0; checked = 0; pivots = 0; arms = 0; clears = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SATURATION: sat_level  = data[SAT_W-1:0];
        CFG_DEAD_BAND:  dead_band  = data[BAND_W-1:0];
        CFG_NEAR_LIMIT: near_limit = data[BAND_W-1:0];
        CFG_FAR_LIMIT:  far_limit  = data[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    function steer_t predict_steer(sample_t s);
      steer_t res;
      int pos, mag, v, i, band2, near2, far2;
      pos = 0;
      for (i = 0; i < NUM_SENSORS; i++) begin
        v = (s[i] >= sat_level) ? SAT_VALUE : int'(s[i]);
        pos += (2 * i - 7) * v;
      end
      band2 = 2 * int'(dead_band);
      near2 = 2 * int'(near_limit);
      far2  = 2 * int'(far_limit);
      mag   = (pos < 0) ? -pos : pos;
      res.drive_update = 1'b0;
      res.left_speed   = SPD_STOP;
      res.right_speed  = SPD_STOP;
      res.led          = LED_KEEP;
      if (pos == 0 || (mag < band2 && turn_mode == TURN_STRAIGHT)) begin
        turn_mode        = TURN_STRAIGHT;
        res.drive_update = 1'b1;
        res.left_speed   = SPD_CRUISE_LEFT;
        res.right_speed  = SPD_CRUISE_RIGHT;
        res.led          = LED_GREEN;
      end else if (mag < band2) begin
        // was turning: drop the turn, command nothing
        turn_mode = TURN_STRAIGHT;
        clears++;
      end else if (pos < 0) begin
        if (turn_mode == TURN_LEFT) begin
          res.drive_update = 1'b1;
          res.led          = LED_BLUE;
          if (pos < -far2)       res.left_speed = SPD_PIVOT_FAST;
          else if (pos > -near2) res.left_speed = SPD_PIVOT_MID;
          else                   res.left_speed = SPD_PIVOT_SLOW;
          pivots++;
        end else begin
          turn_mode = TURN_LEFT;
          arms++;
        end
      end else begin
        res.led = LED_RED;
        if (turn_mode == TURN_RIGHT) begin
          res.drive_update = 1'b1;
          if (pos > far2)       res.right_speed = SPD_PIVOT_FAST;
          else if (pos < near2) res.right_speed = SPD_PIVOT_MID;
          else                  res.right_speed = SPD_PIVOT_SLOW;
          pivots++;
        end else begin
          turn_mode = TURN_RIGHT;
          arms++;
        end
      end
      res.mode = turn_mode;
      return res;
    endfunction

    function void note_sample(sample_t s);
      steer_q.push_back(predict_steer(s));
      samples++;
    endfunction

    function void compare_field(string field, int unsigned exp_v, logic [7:0] act_v);
      if (^act_v === 1'bx || act_v != exp_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(steer_t got);
      steer_t exp_r;
      if (steer_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = steer_q.pop_front();
      checked++;
      compare_field("drive_update", exp_r.drive_update, got.drive_update);
      compare_field("left_speed", exp_r.left_speed, got.left_speed);
      compare_field("right_speed", exp_r.right_speed, got.right_speed);
      compare_field("led_colour", exp_r.led, got.led);
      compare_field("turn_mode_out", exp_r.mode, got.mode);
    endfunction

    function int pending();
      return steer_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  steady;
  int                    idle_cycles;
  int                    settings;

  steering_scoreboard sb;

  lfs_sample_if in_chan ();
  lfs_result_if out_chan ();

  line_follow_steering dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side backpressure
  always @(negedge clk) begin
    if (!steady && $urandom_range(99) < 13) out_chan.ready <= 1'b0;
    else out_chan.ready <= 1'b1;
  end

  // Monitor: results are checked before the sample of the same edge is noted
  always @(posedge clk) begin
    steer_t got;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got.drive_update = out_chan.drive_update;
        got.left_speed   = out_chan.left_speed;
        got.right_speed  = out_chan.right_speed;
        got.led          = led_t'(out_chan.led_colour);
        got.mode         = turn_mode_t'(out_chan.turn_mode_out);
        sb.check_result(got);
      end
      if (in_chan.valid && in_chan.ready)
        sb.note_sample({in_chan.reading_7, in_chan.reading_6, in_chan.reading_5,
                        in_chan.reading_4, in_chan.reading_3, in_chan.reading_2,
                        in_chan.reading_1, in_chan.reading_0});
      if (cfg_we) sb.write_reg(cfg_idx_t'(cfg_index), cfg_wdata);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(99) < 13) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.reading_0 <= s[0];
    in_chan.reading_1 <= s[1];
    in_chan.reading_2 <= s[2];
    in_chan.reading_3 <= s[3];
    in_chan.reading_4 <= s[4];
    in_chan.reading_5 <= s[5];
    in_chan.reading_6 <= s[6];
    in_chan.reading_7 <= s[7];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_single(input int idx, input logic [LFS_READING_WIDTH-1:0] val);
    sample_t s;
    s = '0;
    s[idx] = val;
    send_sample(s);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input int sat, input int db, input int nl, input int fl);
    cfg_we <= 1'b1; cfg_index <= CFG_SATURATION; cfg_wdata <= CFG_DATA_W'(sat);
    @(negedge clk);
    cfg_index <= CFG_DEAD_BAND; cfg_wdata <= CFG_DATA_W'(db);
    @(negedge clk);
    cfg_index <= CFG_NEAR_LIMIT; cfg_wdata <= CFG_DATA_W'(nl);
    @(negedge clk);
    cfg_index <= CFG_FAR_LIMIT; cfg_wdata <= CFG_DATA_W'(fl);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // heading: 0 line to the left, 1 to the right, 2 centered, else raw noise
  function automatic sample_t make_sample(input int heading, input int span);
    sample_t s;
    int i;
    for (i = 0; i < NUM_SENSORS; i++) begin
      case (heading)
        0: s[i] = (i < 4) ? LFS_READING_WIDTH'($urandom_range(span))
                          : LFS_READING_WIDTH'($urandom_range(span / 4));
        1: s[i] = (i >= 4) ? LFS_READING_WIDTH'($urandom_range(span))
                           : LFS_READING_WIDTH'($urandom_range(span / 4));
        2: s[i] = LFS_READING_WIDTH'($urandom_range(span / 8));
        default: s[i] = LFS_READING_WIDTH'($urandom());
      endcase
    end
    if ($urandom_range(9) == 0)
      s[$urandom_range(NUM_SENSORS - 1)] = LFS_READING_WIDTH'($urandom());
    return s;
  endfunction

  // Runs of same-heading samples so turns arm and then pivot
  task automatic run_random(input int count);
    int done, run_len, heading, span;
    done = 0;
    while (done < count) begin
      heading = ($urandom_range(9) < 2) ? 3 : $urandom_range(2);
      run_len = $urandom_range(1, 6);
      case ($urandom_range(5))
        0: span = 8;
        1: span = 20;
        2: span = 60;
        3: span = 300;
        4: span = 4000;
        default: span = 65535;
      endcase
      repeat (run_len) begin
        if (done < count) begin
          send_sample(make_sample(heading, span));
          done++;
        end
      end
    end
  endtask

  initial begin
    sample_t s;
    sb = new();
    steady = 1'b0;
    idle_cycles = 0;
    settings = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SATURATION;
    cfg_wdata = '0;
    out_chan.ready = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.reading_0 = '0; in_chan.reading_1 = '0;
    in_chan.reading_2 = '0; in_chan.reading_3 = '0;
    in_chan.reading_4 = '0; in_chan.reading_5 = '0;
    in_chan.reading_6 = '0; in_chan.reading_7 = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the turn memory at reset thresholds (40/50/60 doubled)
    send_single(0, 16'd0);        // zero sum
    send_sample({NUM_SENSORS{16'hFFFF}});  // all saturated, sums to zero
    send_single(4, 16'd30);       // inside band while straight
    send_single(0, 16'd10);       // arm left
    send_single(0, 16'd10);       // left pivot fast
    send_single(0, 16'd7);        // left pivot mid
    send_single(1, 16'd12);       // exactly at far limit: slow
    send_single(3, 16'd39);       // inside band while turning: clear
    send_single(7, 16'd6);        // arm right
    send_single(7, 16'd10);       // right pivot fast
    send_single(7, 16'd7);        // right pivot mid
    send_single(6, 16'd12);       // exactly at far limit: slow
    send_single(4, 16'd40);       // exactly at dead band edge counts as beyond
    send_single(0, 16'd1000);     // reading equal to saturation counts as five
    send_single(0, 16'd999);      // just below saturation
    s = '0; s[0] = 16'd999; s[7] = 16'd999;
    send_sample(s);
    send_single(7, 16'hFFFF);
    s = '0; s[4] = 16'd999; s[5] = 16'd999; s[6] = 16'd999; s[7] = 16'd999;
    send_sample(s);
    send_sample(s);
    s = '0; s[0] = 16'd999; s[1] = 16'd999; s[2] = 16'd999; s[3] = 16'd999;
    send_sample(s);
    send_sample({NUM_SENSORS / 2{16'hAAAA, 16'h5555}});
    send_single(3, 16'd40);
    send_single(3, 16'd40);
    run_random(100);

    wait_drained();
    apply_settings(0, 20, 25, 30);            // everything saturates
    run_random(40);

    wait_drained();
    apply_settings(65535, 0, 16000, 16000);   // no dead band, widest limits
    steady = 1'b1;
    run_random(110);
    wait_drained();
    steady = 1'b0;

    apply_settings(300, 16000, 0, 0);         // widest band, unordered limits
    run_random(60);

    wait_drained();
    apply_settings(65535, 16000, 0, 0);
    run_random(80);

    wait_drained();
    apply_settings($urandom_range(50, 3000), $urandom_range(0, 200),
                   $urandom_range(0, 400), $urandom_range(0, 400));
    run_random(110);

    wait_drained();
    apply_settings(SAT_LEVEL_RST, DEAD_BAND_RST, NEAR_LIMIT_RST, FAR_LIMIT_RST);
    run_random(110);

    wait_drained();
    $display("Ran %0d samples under %0d register settings, %0d results checked.",
             sb.samples, settings, sb.checked);
    $display("Turn memory: %0d arming samples, %0d pivots, %0d band clears.",
             sb.arms, sb.pivots, sb.clears);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0t: %0d errors, %0d results still expected", $time, sb.errors,
               sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lfs_pkg.sv
rtl/core/lfs_chan_if.sv
rtl/core/lfs_cfg_regs.sv
rtl/core/lfs_pos_sum.sv
rtl/core/lfs_steer_ctrl.sv
rtl/core/line_follow_steering.sv
rtl/core/lfs_checker.sv
dv/line_follow_steering_tb.sv
